>>> src/differential_pressure_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// differential pressure frame decoder assertion macros
// shared property forms used by the decoder's rtl
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_PRESSURE_FRAME_DECODER_ASSERT_SVH
`define DIFFERENTIAL_PRESSURE_FRAME_DECODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DPFD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpfd assertion failed");

// consequent must hold in the cycle after the antecedent
`define DPFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpfd assertion failed");

`endif

>>> src/dpfd_pkg.sv
// ----------------------------------------------------------------------------
// dpfd_pkg
// shared constants and types of the differential pressure frame decoder
// ----------------------------------------------------------------------------
package dpfd_pkg;

   localparam int BYTE_W        = 8;
   localparam int RAW_W         = 16;
   localparam int ST_W          = 3;
   localparam int PQ_W          = 24;
   localparam int TQ_W          = 17;
   localparam int FRAC_BITS_DEF = 8;
   localparam int REQ_DATA_W    = 8;
   localparam int RSP_DATA_W    = 96;
   localparam int RSP_PAD_W     = RSP_DATA_W - (ST_W + 3 * RAW_W + 1 + PQ_W + TQ_W);

   // status codes
   localparam logic [ST_W-1:0] ST_OK         = 3'd0;
   localparam logic [ST_W-1:0] ST_PRESS_CRC  = 3'd1;
   localparam logic [ST_W-1:0] ST_TEMP_CRC   = 3'd2;
   localparam logic [ST_W-1:0] ST_SCALE_CRC  = 3'd3;
   localparam logic [ST_W-1:0] ST_ZERO_SCALE = 3'd4;

   localparam logic [RAW_W-1:0] TEMP_DIVISOR = 16'd200;

   // controller to datapath commands
   typedef struct packed {
      logic byte_en;     // request accepted this cycle
      logic div_load_p;  // load divider with pressure / scale
      logic div_step;    // one restoring division step
      logic cap_p;       // capture pressure and temperature quotients
      logic load_out;    // load the result register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic frame_end;   // offered byte closes the current frame
   } stat_type;

   typedef struct packed {
      logic [TQ_W-1:0]  temperature_c_q8;
      logic [PQ_W-1:0]  pressure_pa_q8;
      logic             scale_refreshed;
      logic [RAW_W-1:0] scale_factor;
      logic [RAW_W-1:0] temperature_raw;
      logic [RAW_W-1:0] pressure_raw;
      logic [ST_W-1:0]  status;
   } rsp_payload_type;

endpackage

>>> src/differential_pressure_frame_decoder.sv
// ----------------------------------------------------------------------------
// differential_pressure_frame_decoder
// crc-8 checked sensor word frames in, one decoded result per frame out
// ----------------------------------------------------------------------------
// channel   dir  handshake                fields
// req       in   req_tvalid/req_tready    tdata: data_byte; tuser: frame_start
// rsp       out  rsp_tvalid/rsp_tready    tdata: status .. temperature_c_q8
//
// one request byte per cycle while idle; a frame-closing byte stops intake
// through the divide, capture and hold states: pressure / scale runs one bit per
// cycle, temperature / 200 is a reciprocal multiply beside it
// the next byte is taken while a finished result still waits on rsp
// a result that cannot leave because the previous one is stalled holds intake off
// reset clears the parser to idle with long frames expected and no scale latched
// ----------------------------------------------------------------------------
module differential_pressure_frame_decoder #(
   parameter int FRAC_BITS = dpfd_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dpfd_pkg::REQ_DATA_W-1:0]     req_tdata,  // [7:0] data_byte
   input  logic                                req_tuser,  // [0] frame_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] status, [18:3] pressure_raw, [34:19] temperature_raw,
   // [50:35] scale_factor, [51] scale_refreshed, [75:52] pressure_pa_q8,
   // [92:76] temperature_c_q8, [95:93] zero
   output logic [dpfd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import dpfd_pkg::*;

   cmd_type         cmd;
   stat_type        stat;
   rsp_payload_type payload;

   // sequencer: intake, divider steps, result handoff
   dpfd_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // parser, crc check, divider and result register
   dpfd_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_tdata[BYTE_W-1:0]),
      .frame_start (req_tuser),
      .cmd         (cmd),
      .stat        (stat),
      .payload     (payload)
   );

   // payload struct is declared lowest field last, so it packs straight in
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, payload};

endmodule

>>> src/dpfd_ctrl.sv
// ----------------------------------------------------------------------------
// dpfd_ctrl
// frame decoder sequencer: byte intake, pressure division, result handoff
// ----------------------------------------------------------------------------
`include "differential_pressure_frame_decoder_assert.svh"

module dpfd_ctrl #(
   parameter int FRAC_BITS = dpfd_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  dpfd_pkg::stat_type stat,
   output dpfd_pkg::cmd_type  cmd
);
   import dpfd_pkg::*;

   localparam int NUM_W = RAW_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV_P = 3'd1;
   localparam logic [2:0] S_CAP_P = 3'd2;
   localparam logic [2:0] S_HOLD  = 3'd3;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             last_step;
   logic             stepping;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign last_step  = (cnt_ff == CNT_W'(NUM_W - 1));
   assign stepping   = (state_ff == S_DIV_P);

   always_comb begin
      cmd            = '0;
      cmd.byte_en    = req_tvalid && req_tready;
      cmd.div_load_p = cmd.byte_en && stat.frame_end;
      cmd.div_step   = stepping;
      cmd.cap_p      = (state_ff == S_CAP_P);
      cmd.load_out   = (state_ff == S_HOLD) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = stepping ? cnt_ff + CNT_W'(1) : '0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.div_load_p) state_in = S_DIV_P;
         end
         S_DIV_P: begin
            if (last_step) state_in = S_CAP_P;
         end
         S_CAP_P: begin
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (cmd.load_out) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DPFD_ASSERT_NEXT(a_frame_end_divides, clock, reset, cmd.div_load_p, state_ff == S_DIV_P)
   `DPFD_ASSERT_NOW(a_cap_after_div, clock, reset, state_ff == S_CAP_P, $past(state_ff) == S_DIV_P)
   `DPFD_ASSERT_NEXT(a_hold_hands_off, clock, reset, (state_ff == S_HOLD) && !rsp_valid_ff, rsp_valid_ff && (state_ff == S_IDLE))

endmodule

>>> src/dpfd_datapath.sv
// ----------------------------------------------------------------------------
// dpfd_datapath
// byte parser with crc-8 check, restoring divider for pressure, reciprocal
// multiply for temperature, result register
// ----------------------------------------------------------------------------
module dpfd_datapath #(
   parameter int FRAC_BITS = dpfd_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [dpfd_pkg::BYTE_W-1:0]     data_byte,
   input  logic                            frame_start,
   input  dpfd_pkg::cmd_type               cmd,
   output dpfd_pkg::stat_type              stat,
   output dpfd_pkg::rsp_payload_type       payload
);
   import dpfd_pkg::*;

   localparam int NUM_W = RAW_W + FRAC_BITS;
   localparam int EXT_W = ((NUM_W > PQ_W) ? NUM_W : PQ_W) + 1;
   localparam logic [EXT_W-1:0] P_LIM = (EXT_W'(1) << (PQ_W - 1)) - EXT_W'(1);
   localparam logic [EXT_W-1:0] T_LIM = (EXT_W'(1) << (TQ_W - 1)) - EXT_W'(1);

   // temperature / 200 as ((n / 8) * ceil(2^30 / 25)) >> 30, exact while n / 8 < 2^29
   localparam int RCP_W  = 26;
   localparam int RCP_SH = 30;
   localparam int PRE_SH = 3;
   localparam int PROD_W = NUM_W + RCP_W;
   localparam logic [RCP_W-1:0] T_RCP = 26'd42949673;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [3:0] LONG_LAST  = 4'd8;
   localparam logic [3:0] SHORT_LAST = 4'd5;

   localparam logic [1:0] K_HIGH = 2'd0;
   localparam logic [1:0] K_LOW  = 2'd1;
   localparam logic [1:0] K_CRC  = 2'd2;

   function automatic logic [7:0] crc_feed(input logic [7:0] c, input logic [7:0] b);
      logic [7:0] r;
      r = c ^ b;
      for (int k = 0; k < 8; k++) begin
         r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

   // byte kind within a word and word index from the frame position
   function automatic logic [3:0] pos_decode(input logic [3:0] p);
      logic [3:0] r;
      unique case (p)
         4'd0:    r = {2'd0, K_HIGH};
         4'd1:    r = {2'd0, K_LOW};
         4'd2:    r = {2'd0, K_CRC};
         4'd3:    r = {2'd1, K_HIGH};
         4'd4:    r = {2'd1, K_LOW};
         4'd5:    r = {2'd1, K_CRC};
         4'd6:    r = {2'd2, K_HIGH};
         4'd7:    r = {2'd2, K_LOW};
         default: r = {2'd2, K_CRC};
      endcase
      return r;
   endfunction

   function automatic logic [EXT_W-1:0] sat_q(input logic [NUM_W-1:0] mag, input logic neg,
                                              input logic [EXT_W-1:0] lim);
      logic [EXT_W-1:0] m;
      logic [EXT_W-1:0] r;
      m = EXT_W'(mag);
      if (!neg) r = (m > lim) ? lim : m;
      else r = (m > lim + EXT_W'(1)) ? -(lim + EXT_W'(1)) : -m;
      return r;
   endfunction

   function automatic logic [RAW_W-1:0] abs16(input logic [RAW_W-1:0] w);
      return w[RAW_W-1] ? (~w + RAW_W'(1)) : w;
   endfunction

   // parser state
   logic [3:0]       pos_ff, pos_in;
   logic             long_ff, long_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       hold_ff, hold_in;
   logic [RAW_W-1:0] pw_ff, pw_in;
   logic [RAW_W-1:0] tw_ff, tw_in;
   logic [RAW_W-1:0] cand_ff, cand_in;
   logic [RAW_W-1:0] scale_ff, scale_in;
   logic [ST_W-1:0]  err_ff, err_in;
   logic [ST_W-1:0]  res_st_ff, res_st_in;
   logic             res_ref_ff, res_ref_in;

   // divider
   logic [RAW_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [RAW_W-1:0] den_ff;
   logic             neg_ff;
   logic [PQ_W-1:0]  pq_ff;
   logic [TQ_W-1:0]  tq_ff;
   logic [RAW_W:0]   shifted;
   logic [RAW_W+1:0] diff;
   logic             ge;

   // temperature reciprocal multiply
   logic [NUM_W-1:0]  t_num;
   logic [PROD_W-1:0] t_prod;
   logic [NUM_W-1:0]  t_quo;

   rsp_payload_type  payload_ff;

   logic             active;
   logic [3:0]       idx;
   logic [3:0]       dec;
   logic [1:0]       word;
   logic [1:0]       kind;
   logic             last_byte;
   logic [EXT_W-1:0] p_sat, t_sat;
   logic             res_ok;

   assign active    = frame_start || (pos_ff != 4'd0);
   assign idx       = frame_start ? 4'd0 : pos_ff;
   assign dec       = pos_decode(idx);
   assign word      = dec[3:2];
   assign kind      = dec[1:0];
   assign last_byte = idx >= (long_ff ? LONG_LAST : SHORT_LAST);
   assign stat.frame_end = active && last_byte;

   always_comb begin
      logic [ST_W-1:0]  err_base;
      logic [ST_W-1:0]  st;
      logic             refreshed;
      logic [RAW_W-1:0] scale_next;
      pos_in     = pos_ff;
      long_in    = long_ff;
      crc_in     = crc_ff;
      hold_in    = hold_ff;
      pw_in      = pw_ff;
      tw_in      = tw_ff;
      cand_in    = cand_ff;
      scale_in   = scale_ff;
      err_in     = err_ff;
      res_st_in  = res_st_ff;
      res_ref_in = res_ref_ff;
      err_base   = frame_start ? ST_OK : err_ff;
      st         = ST_OK;
      refreshed  = 1'b0;
      scale_next = scale_ff;
      if (cmd.byte_en && active) begin
         err_in = err_base;
         unique case (kind)
            K_HIGH: begin
               crc_in  = crc_feed(CRC_INIT, data_byte);
               hold_in = data_byte;
            end
            K_LOW: begin
               crc_in = crc_feed(crc_ff, data_byte);
               unique case (word)
                  2'd0:    pw_in   = {hold_ff, data_byte};
                  2'd1:    tw_in   = {hold_ff, data_byte};
                  default: cand_in = {hold_ff, data_byte};
               endcase
            end
            default: begin
               if ((data_byte != crc_ff) && (err_base == ST_OK)) begin
                  unique case (word)
                     2'd0:    err_in = ST_PRESS_CRC;
                     2'd1:    err_in = ST_TEMP_CRC;
                     default: err_in = ST_SCALE_CRC;
                  endcase
               end
               crc_in = CRC_INIT;
            end
         endcase
         if (last_byte) begin
            pos_in = 4'd0;
            st     = err_in;
            if (long_ff && (st == ST_OK)) begin
               if (cand_in == '0) begin
                  st = ST_ZERO_SCALE;
               end else begin
                  scale_next = cand_in;
                  refreshed  = 1'b1;
               end
            end
            if ((st == ST_OK) && (scale_next == '0)) st = ST_ZERO_SCALE;
            scale_in   = scale_next;
            long_in    = (scale_next == '0);
            res_st_in  = st;
            res_ref_in = refreshed;
         end else begin
            pos_in = idx + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 4'd0;
         long_ff  <= 1'b1;
         crc_ff   <= CRC_INIT;
         err_ff   <= ST_OK;
         scale_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         long_ff  <= long_in;
         crc_ff   <= crc_in;
         err_ff   <= err_in;
         scale_ff <= scale_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff    <= hold_in;
      pw_ff      <= pw_in;
      tw_ff      <= tw_in;
      cand_ff    <= cand_in;
      res_st_ff  <= res_st_in;
      res_ref_ff <= res_ref_in;
   end

   // restoring division on magnitudes, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign ge      = !diff[RAW_W+1];
   assign p_sat   = sat_q(quo_ff, neg_ff, P_LIM);
   assign res_ok  = (res_st_ff == ST_OK);

   // temperature magnitude quotient, settles while the pressure divider runs
   assign t_num  = (NUM_W'(abs16(tw_ff)) << FRAC_BITS) >> PRE_SH;
   assign t_prod = PROD_W'(t_num) * PROD_W'(T_RCP);
   assign t_quo  = NUM_W'(t_prod >> RCP_SH);
   assign t_sat  = sat_q(t_quo, tw_ff[RAW_W-1], T_LIM);

   always_ff @(posedge clock) begin
      if (cmd.div_load_p) begin
         rem_ff <= '0;
         quo_ff <= NUM_W'(abs16(pw_in)) << FRAC_BITS;
         den_ff <= scale_in;
         neg_ff <= pw_in[RAW_W-1];
      end else if (cmd.div_step) begin
         rem_ff <= ge ? diff[RAW_W-1:0] : shifted[RAW_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
      if (cmd.cap_p) begin
         pq_ff <= p_sat[PQ_W-1:0];
         tq_ff <= t_sat[TQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         payload_ff.status           <= res_st_ff;
         payload_ff.pressure_raw     <= pw_ff;
         payload_ff.temperature_raw  <= tw_ff;
         payload_ff.scale_factor     <= scale_ff;
         payload_ff.scale_refreshed  <= res_ref_ff;
         payload_ff.pressure_pa_q8   <= res_ok ? pq_ff : '0;
         payload_ff.temperature_c_q8 <= res_ok ? tq_ff : '0;
      end
   end

   assign payload = payload_ff;

endmodule

>>> tb/sv/differential_pressure_frame_decoder_tb.sv
// ----------------------------------------------------------------------------
// differential_pressure_frame_decoder_tb
// drives sensor read-back bytes into the frame decoder with bursty offers and
// random result back-pressure, decodes every accepted byte in a local model of
// the frame parser and compares each result field with the oldest prediction
// ----------------------------------------------------------------------------
module differential_pressure_frame_decoder_tb;

   import dpfd_pkg::*;

   localparam int          FRAC         = FRAC_BITS_DEF;
   localparam int unsigned LONG_LEN     = 9;
   localparam int unsigned SHORT_LEN    = 6;
   localparam logic [7:0]  CRC_INIT     = 8'hFF;
   localparam logic [7:0]  CRC_POLY     = 8'h31;
   localparam longint      PQ_MAX       = 2**(PQ_W-1) - 1;
   localparam longint      PQ_MIN       = -(2**(PQ_W-1));
   localparam longint      TQ_MAX       = 2**(TQ_W-1) - 1;
   localparam longint      TQ_MIN       = -(2**(TQ_W-1));
   localparam int          ITEMS        = 1400;
   localparam int          HOLD_AT      = 400;   // request count that starts the long stall
   localparam int          HOLD_CYCLES  = 800;
   localparam int          DRAIN_CYCLES = 120;   // well over one divide pass

   typedef struct {
      logic [7:0] data;
      logic       sof;
      bit         hold;    // wait for every outstanding result before offering
   } sensor_byte_type;

   typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_TOGGLE} ready_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [7:0] data_byte
   logic                  req_tuser  = 1'b0; // [0] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [2:0] status, [18:3] pressure_raw, [34:19] temperature_raw,
   // [50:35] scale_factor, [51] scale_refreshed, [75:52] pressure_pa_q8,
   // [92:76] temperature_c_q8, [95:93] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   differential_pressure_frame_decoder #(
      .FRAC_BITS(FRAC)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // frame parser model
   // ---------------------------------------------------------------------------
   logic [3:0]      parse_pos     = '0;
   logic            expect_long   = 1'b1;
   logic [7:0]      crc_acc       = CRC_INIT;
   logic [7:0]      hi_hold       = '0;
   logic [RAW_W-1:0] press_word   = '0;
   logic [RAW_W-1:0] temp_word    = '0;
   logic [ST_W-1:0] fault         = ST_OK;
   logic [RAW_W-1:0] scale_held   = '0;
   logic [RAW_W-1:0] scale_pending = '0;

   function automatic logic [7:0] crc8_next(logic [7:0] c, logic [7:0] b);
      logic [7:0] x;
      x = c ^ b;
      for (int k = 0; k < 8; k++) x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
      return x;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic sof,
                              output bit made, output rsp_payload_type r);
      int unsigned slot;
      int unsigned word_no;
      logic [ST_W-1:0] st;
      logic fresh;
      longint pq;
      longint tq;
      made  = 0;
      r     = '0;
      fresh = 1'b0;
      pq    = 0;
      tq    = 0;
      // a start always reopens the frame, otherwise idle bytes fall through
      if (sof) begin
         parse_pos = '0;
         crc_acc   = CRC_INIT;
         fault     = ST_OK;
      end else if (parse_pos == 0) begin
         return;
      end
      slot    = parse_pos;
      word_no = slot / 3;
      case (slot % 3)
         0: begin
            crc_acc = crc8_next(CRC_INIT, b);
            hi_hold = b;
         end
         1: begin
            crc_acc = crc8_next(crc_acc, b);
            case (word_no)
               0:       press_word    = {hi_hold, b};
               1:       temp_word     = {hi_hold, b};
               default: scale_pending = {hi_hold, b};
            endcase
         end
         default: begin
            // first bad word wins, the rest of the frame is still parsed
            if (b != crc_acc && fault == ST_OK)
               fault = (word_no == 0) ? ST_PRESS_CRC :
                       (word_no == 1) ? ST_TEMP_CRC : ST_SCALE_CRC;
            crc_acc = CRC_INIT;
         end
      endcase
      slot++;
      if (slot < (expect_long ? LONG_LEN : SHORT_LEN)) begin
         parse_pos = 4'(slot);
         return;
      end
      parse_pos = '0;
      st = fault;
      if (expect_long && st == ST_OK) begin
         if (scale_pending == 0) begin
            st = ST_ZERO_SCALE;
         end else begin
            scale_held = scale_pending;
            fresh      = 1'b1;
         end
      end
      if (st == ST_OK && scale_held == 0) st = ST_ZERO_SCALE;
      expect_long = (scale_held == 0);
      if (st == ST_OK) begin
         pq = longint'($signed(press_word)) * (longint'(1) << FRAC) / longint'(scale_held);
         tq = longint'($signed(temp_word)) * (longint'(1) << FRAC) / longint'(TEMP_DIVISOR);
         pq = (pq > PQ_MAX) ? PQ_MAX : ((pq < PQ_MIN) ? PQ_MIN : pq);
         tq = (tq > TQ_MAX) ? TQ_MAX : ((tq < TQ_MIN) ? TQ_MIN : tq);
      end
      r.status           = st;
      r.pressure_raw     = press_word;
      r.temperature_raw  = temp_word;
      r.scale_factor     = scale_held;
      r.scale_refreshed  = fresh;
      r.pressure_pa_q8   = pq[PQ_W-1:0];
      r.temperature_c_q8 = tq[TQ_W-1:0];
      made = 1;
   endtask

   // ---------------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------------
   sensor_byte_type sensor_bytes[$];
   rsp_payload_type pending_results[$];
   bit              hold_next = 0;

   task automatic add_byte(input logic [7:0] b, input logic sof);
      sensor_byte_type item;
      item.data = b;
      item.sof  = sof;
      item.hold = hold_next;
      hold_next = 0;
      sensor_bytes.push_back(item);
   endtask

   task automatic add_word(input logic [15:0] w, input logic sof, input bit bad);
      logic [7:0] c;
      c = crc8_next(crc8_next(CRC_INIT, w[15:8]), w[7:0]);
      if (bad) c = c ^ 8'($urandom_range(1, 255));
      add_byte(w[15:8], sof);
      add_byte(w[7:0], 1'b0);
      add_byte(c, 1'b0);
   endtask

   // bad_mask bit 0 pressure, 1 temperature, 2 scale
   task automatic add_frame(input logic [15:0] p, input logic [15:0] t, input logic [15:0] s,
                            input bit with_scale, input logic [2:0] bad_mask);
      add_word(p, 1'b1, bad_mask[0]);
      add_word(t, 1'b0, bad_mask[1]);
      if (with_scale) add_word(s, 1'b0, bad_mask[2]);
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [2:0] pick_bad();
      logic [2:0] m;
      for (int k = 0; k < 3; k++) m[k] = ($urandom_range(0, 11) == 0);
      return m;
   endfunction

   // ---------------------------------------------------------------------------
   // driver: bursts of offers with random gaps, prediction on acceptance
   // ---------------------------------------------------------------------------
   int              bytes_taken   = 0;
   int              results_due   = 0;
   int              results_seen  = 0;
   int              burst_left    = 0;
   int              gap_left      = 0;
   bit              just_closed;
   bit              made;
   rsp_payload_type predicted;
   sensor_byte_type head;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid  <= 1'b0;
         req_tdata   <= '0;
         req_tuser   <= 1'b0;
         bytes_taken <= 0;
         results_due <= 0;
         burst_left  = 0;
         gap_left    = 0;
      end else begin
         just_closed = 0;
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tuser, made, predicted);
            if (made) begin
               pending_results.push_back(predicted);
               results_due <= results_due + 1;
               just_closed = 1;
            end
            bytes_taken <= bytes_taken + 1;
         end
         // an offer that is still waiting stays as it is
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (sensor_bytes.size() != 0 &&
                         (!sensor_bytes[0].hold ||
                          (results_seen == results_due && !just_closed))) begin
               head = sensor_bytes.pop_front();
               req_tdata  <= head.data;
               req_tuser  <= head.sof;
               req_tvalid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // long receiver stall, counted on its own
   // ---------------------------------------------------------------------------
   int hold_left = 0;
   bit hold_done = 0;

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 0;
      end else if (bytes_taken == HOLD_AT && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: ready pattern and result check
   // ---------------------------------------------------------------------------
   int              mismatches = 0;
   ready_mode_type  ready_mode = RDY_ALWAYS;
   int              mode_left  = 0;
   logic            ready_next;
   rsp_payload_type observed;
   rsp_payload_type wanted;

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready   <= 1'b0;
         results_seen <= 0;
         mode_left    = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            observed = rsp_payload_type'(rsp_tdata[$bits(rsp_payload_type)-1:0]);
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               wanted = pending_results.pop_front();
               compare_field("status", 32'(wanted.status), 32'(observed.status));
               compare_field("pressure_raw", 32'(wanted.pressure_raw),
                             32'(observed.pressure_raw));
               compare_field("temperature_raw", 32'(wanted.temperature_raw),
                             32'(observed.temperature_raw));
               compare_field("scale_factor", 32'(wanted.scale_factor),
                             32'(observed.scale_factor));
               compare_field("scale_refreshed", 32'(wanted.scale_refreshed),
                             32'(observed.scale_refreshed));
               compare_field("pressure_pa_q8", 32'(wanted.pressure_pa_q8),
                             32'(observed.pressure_pa_q8));
               compare_field("temperature_c_q8", 32'(wanted.temperature_c_q8),
                             32'(observed.temperature_c_q8));
               compare_field("pad", 32'(0), 32'(rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W]));
            end
            results_seen <= results_seen + 1;
         end
         // ready pattern switches to a randomly picked mode once its mode counter runs out
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(30, 200);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            RDY_ALWAYS: ready_next = 1'b1;
            RDY_HALF:   ready_next = $urandom_range(0, 1);
            RDY_SPARSE: ready_next = ($urandom_range(0, 7) == 0);
            default:    ready_next = ~rsp_tready;
         endcase
         rsp_tready <= ready_next && (hold_left == 0);
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------
   logic [15:0] scale_pick;
   int          pick;
   int          base;
   int          len;
   bit          mid_hold_set;

   initial begin
      // directed: scale word crc error, zero scale, then the latching frame
      case ($urandom_range(0, 3))
         0:       scale_pick = 16'h0001;
         1:       scale_pick = 16'hFFFF;
         2:       scale_pick = 16'($urandom_range(2, 300));
         default: scale_pick = 16'($urandom_range(1, 65535));
      endcase
      add_frame(16'h7FFF, 16'h8000, 16'h1234, 1, 3'b100);
      add_frame(16'h8000, 16'h7FFF, 16'h0000, 1, 3'b000);
      add_frame(16'h8000, 16'h8000, scale_pick, 1, 3'b000);

      // random: mostly short frames, some noise and broken frames
      hold_next    = 1;
      mid_hold_set = 0;
      while (sensor_bytes.size() < ITEMS) begin
         if (!mid_hold_set && sensor_bytes.size() > ITEMS / 2) begin
            hold_next    = 1;
            mid_hold_set = 1;
         end
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            add_frame(pick_word(), pick_word(), 16'h0000, 0, pick_bad());
         end else if (pick == 14) begin
            // loose bytes, ignored while idle
            len = $urandom_range(1, 4);
            repeat (len) add_byte(8'($urandom), 1'b0);
         end else if (pick == 15) begin
            // truncated frame, abandoned by the next start
            len = $urandom_range(1, 5);
            add_byte(8'($urandom), 1'b1);
            repeat (len - 1) add_byte(8'($urandom), 1'b0);
         end else if (pick == 16) begin
            // long frame shape, the tail after six bytes is ignored
            add_frame(pick_word(), pick_word(), pick_word(), 1, pick_bad());
         end else if (pick == 17) begin
            // stray start inside a frame resyncs the parser
            base = sensor_bytes.size();
            add_frame(pick_word(), pick_word(), 16'h0000, 0, 3'b000);
            sensor_bytes[base + $urandom_range(1, 5)].sof = 1'b1;
         end else begin
            // garbage frame, crcs almost always wrong
            add_byte(8'($urandom), 1'b1);
            repeat (SHORT_LEN - 1) add_byte(8'($urandom), 1'b0);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (sensor_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (results_seen != results_due) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         $display("%0t: %0d results never arrived", $time, pending_results.size());
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("differential_pressure_frame_decoder_tb OK");
      end else begin
         $display("differential_pressure_frame_decoder_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("%0t: timeout", $time);
      $display("differential_pressure_frame_decoder_tb NOT OK");
      $finish;
   end

endmodule
